FILE: design/rth_pkg.sv
package rth_pkg;

    // channel and result widths
    localparam int CHAN_W  = 8;
    localparam int SUM_W   = 9;
    localparam int DIFF_W  = 9;
    localparam int HUE_W   = 9;
    localparam int SAT_W   = 7;
    localparam int LIGHT_W = 7;

    // divider geometry: one quotient bit per stage
    localparam int QUO_W   = 9;
    localparam int HNUM_W  = 18;
    localparam int SNUM_W  = 17;
    localparam int DEN_W   = 9;
    localparam int TERM_W  = 17;

    // lightness: floor((20*sum + 51) / 102) by exact reciprocal
    localparam int LX_W        = 14;
    localparam int LIGHT_SCALE = 20;
    localparam int LIGHT_BIAS  = 51;
    localparam int LIGHT_RECIP = 20561;
    localparam int LIGHT_SHIFT = 21;
    localparam int PROD_W      = 29;

    // hue and saturation constants
    localparam int HUE_STEP  = 60;
    localparam int SEXT_W    = 120;
    localparam int SAT_SCALE = 200;
    localparam int HUE_MAX   = 360;
    localparam int PCT_MAX   = 100;

    // start to strobe, in clocks
    localparam int LATENCY = QUO_W + 3;

    typedef enum logic [1:0] {
        HB_0,
        HB_120,
        HB_240,
        HB_360
    } t_hue_base;

    typedef struct packed {
        logic              grey;
        logic [HNUM_W-1:0] hrem;
        logic [DEN_W-1:0]  hden;
        logic [SNUM_W-1:0] srem;
        logic [DEN_W-1:0]  sden;
        logic [QUO_W-1:0]  hq;
        logic [QUO_W-1:0]  sq;
        logic [LIGHT_W-1:0] light;
    } t_div_stage;

endpackage

FILE: design/rgb_to_hsl_core.sv
// rgb to hsl pixel converter. one rgb word of three 8-bit channels is taken at every
// clock edge where start is high; busy never rises, so a new pixel may follow in
// every cycle. the matching hsl word (hue 0..360 degrees, saturation and lightness
// 0..100 percent, all rounded half up) appears on the o_ ports for exactly one cycle
// with o_strobe high, in input order. the receiver cannot stall the block and must
// take each word in the cycle it is shown. the pipeline is the two stages of min/max
// and numerator setup, a nine-stage restoring divider (one quotient bit per stage)
// that serves hue and saturation side by side, and the output register.
module rgb_to_hsl_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rth_pkg::CHAN_W-1:0]   i_red_in,
    input  logic [rth_pkg::CHAN_W-1:0]   i_green_in,
    input  logic [rth_pkg::CHAN_W-1:0]   i_blue_in,
    output logic                         o_strobe,
    output logic [rth_pkg::HUE_W-1:0]    o_hue_deg,
    output logic [rth_pkg::SAT_W-1:0]    o_sat_pct,
    output logic [rth_pkg::LIGHT_W-1:0]  o_light_pct
);

    localparam int QW = rth_pkg::QUO_W;

    // ---------------------------------------------------------------
    // stage 1: max, min, spread and which channel leads
    // ---------------------------------------------------------------
    logic                                n_v1;
    logic [rth_pkg::CHAN_W-1:0]          n_mx, n_mn;
    logic [rth_pkg::CHAN_W-1:0]          n_d1;
    logic [rth_pkg::SUM_W-1:0]           n_sum1;
    logic signed [rth_pkg::DIFF_W-1:0]   n_diff1;
    rth_pkg::t_hue_base                  n_base1;

    logic                                r_v1;
    logic [rth_pkg::CHAN_W-1:0]          r_d1;
    logic [rth_pkg::SUM_W-1:0]           r_sum1;
    logic signed [rth_pkg::DIFF_W-1:0]   r_diff1;
    rth_pkg::t_hue_base                  r_base1;

    assign busy = 1'b0;
    assign n_v1 = start && !busy;

    always_comb begin
        n_mx = i_red_in;
        n_mn = i_red_in;
        if (i_green_in > n_mx) n_mx = i_green_in;
        if (i_blue_in > n_mx)  n_mx = i_blue_in;
        if (i_green_in < n_mn) n_mn = i_green_in;
        if (i_blue_in < n_mn)  n_mn = i_blue_in;
        n_d1   = n_mx - n_mn;
        n_sum1 = rth_pkg::SUM_W'(n_mx) + rth_pkg::SUM_W'(n_mn);

        // ties: red over green, green over blue
        if (i_red_in >= i_green_in && i_red_in >= i_blue_in) begin
            n_diff1 = {1'b0, i_green_in} - {1'b0, i_blue_in};
            n_base1 = (i_green_in < i_blue_in) ? rth_pkg::HB_360 : rth_pkg::HB_0;
        end else if (i_green_in >= i_blue_in) begin
            n_diff1 = {1'b0, i_blue_in} - {1'b0, i_red_in};
            n_base1 = rth_pkg::HB_120;
        end else begin
            n_diff1 = {1'b0, i_red_in} - {1'b0, i_green_in};
            n_base1 = rth_pkg::HB_240;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: numerators and divisors
    // hue:  (2n + d) / 2d,  n = 60*diff + sextant base * d
    // sat:  (200d + den) / 2den
    // light numerator 20*sum + 51, divided by 102 one stage later
    // ---------------------------------------------------------------
    logic [rth_pkg::TERM_W-1:0]          base_term;
    logic signed [rth_pkg::HNUM_W:0]     hue_n;
    logic [rth_pkg::DEN_W-1:0]           sat_den;
    rth_pkg::t_div_stage                 n_st0;
    rth_pkg::t_div_stage                 n_st [1:QW];
    logic [rth_pkg::LX_W-1:0]            n_lx;

    always_comb begin
        case (r_base1)
            rth_pkg::HB_0:   base_term = '0;
            rth_pkg::HB_120: base_term = rth_pkg::TERM_W'(r_d1) *
                                         rth_pkg::TERM_W'(rth_pkg::SEXT_W);
            rth_pkg::HB_240: base_term = rth_pkg::TERM_W'(r_d1) *
                                         rth_pkg::TERM_W'(2 * rth_pkg::SEXT_W);
            rth_pkg::HB_360: base_term = rth_pkg::TERM_W'(r_d1) *
                                         rth_pkg::TERM_W'(3 * rth_pkg::SEXT_W);
            default:         base_term = '0;
        endcase

        // never negative: the leading channel bounds diff by d
        hue_n = (rth_pkg::HNUM_W+1)'(r_diff1) *
                    (rth_pkg::HNUM_W+1)'(signed'(rth_pkg::HUE_STEP))
              + signed'({2'b00, base_term});

        sat_den = r_sum1[rth_pkg::SUM_W-1] ?
                  (rth_pkg::DEN_W'(2 * 255) - r_sum1) : r_sum1;

        n_st0.grey  = (r_d1 == '0);
        n_st0.hrem  = {hue_n[rth_pkg::HNUM_W-2:0], 1'b0} + rth_pkg::HNUM_W'(r_d1);
        n_st0.hden  = {r_d1, 1'b0};
        n_st0.srem  = rth_pkg::SNUM_W'(r_d1) * rth_pkg::SNUM_W'(rth_pkg::SAT_SCALE)
                    + rth_pkg::SNUM_W'(sat_den);
        n_st0.sden  = {sat_den[rth_pkg::DEN_W-2:0], 1'b0};
        n_st0.hq    = '0;
        n_st0.sq    = '0;
        n_st0.light = '0;

        n_lx = rth_pkg::LX_W'(r_sum1) * rth_pkg::LX_W'(rth_pkg::LIGHT_SCALE)
             + rth_pkg::LX_W'(rth_pkg::LIGHT_BIAS);
    end

    // ---------------------------------------------------------------
    // divider stages: restoring, msb first, hue and sat in parallel
    // ---------------------------------------------------------------
    logic [QW:0]                         r_dv;
    rth_pkg::t_div_stage                 r_st [0:QW];
    logic [rth_pkg::LX_W-1:0]            r_lx;
    logic [rth_pkg::PROD_W-1:0]          light_prod;

    always_comb begin
        logic [rth_pkg::HNUM_W-1:0] hsh;
        logic [rth_pkg::SNUM_W-1:0] ssh;
        for (int k = 0; k < QW; k++) begin
            n_st[k+1] = r_st[k];
            hsh = rth_pkg::HNUM_W'(r_st[k].hden) << (QW - 1 - k);
            ssh = rth_pkg::SNUM_W'(r_st[k].sden) << (QW - 1 - k);
            if (r_st[k].hrem >= hsh) begin
                n_st[k+1].hrem          = r_st[k].hrem - hsh;
                n_st[k+1].hq[QW-1-k]    = 1'b1;
            end
            if (r_st[k].srem >= ssh) begin
                n_st[k+1].srem          = r_st[k].srem - ssh;
                n_st[k+1].sq[QW-1-k]    = 1'b1;
            end
        end
        // lightness rides the first divider stage: exact reciprocal of 102
        light_prod = rth_pkg::PROD_W'(r_lx) * rth_pkg::PROD_W'(rth_pkg::LIGHT_RECIP);
        n_st[1].light = light_prod[rth_pkg::LIGHT_SHIFT +: rth_pkg::LIGHT_W];
    end

    // ---------------------------------------------------------------
    // output: grey override and clamps
    // ---------------------------------------------------------------
    logic [rth_pkg::HUE_W-1:0]   n_hue;
    logic [rth_pkg::SAT_W-1:0]   n_sat;
    logic [rth_pkg::LIGHT_W-1:0] n_light;

    always_comb begin
        if (r_st[QW].grey) begin
            n_hue = '0;
            n_sat = '0;
        end else begin
            n_hue = (r_st[QW].hq > rth_pkg::QUO_W'(rth_pkg::HUE_MAX)) ?
                    rth_pkg::HUE_W'(rth_pkg::HUE_MAX) : rth_pkg::HUE_W'(r_st[QW].hq);
            n_sat = (r_st[QW].sq > rth_pkg::QUO_W'(rth_pkg::PCT_MAX)) ?
                    rth_pkg::SAT_W'(rth_pkg::PCT_MAX) : r_st[QW].sq[rth_pkg::SAT_W-1:0];
        end
        n_light = (r_st[QW].light > rth_pkg::LIGHT_W'(rth_pkg::PCT_MAX)) ?
                  rth_pkg::LIGHT_W'(rth_pkg::PCT_MAX) : r_st[QW].light;
    end

    logic                        r_out_v;
    logic [rth_pkg::HUE_W-1:0]   r_hue;
    logic [rth_pkg::SAT_W-1:0]   r_sat;
    logic [rth_pkg::LIGHT_W-1:0] r_light;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_dv    <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_v1    <= n_v1;
            r_dv    <= {r_dv[QW-1:0], r_v1};
            r_out_v <= r_dv[QW];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_d1    <= n_d1;
        r_sum1  <= n_sum1;
        r_diff1 <= n_diff1;
        r_base1 <= n_base1;
        r_lx    <= n_lx;
        r_st[0] <= n_st0;
        for (int k = 1; k <= QW; k++) begin
            r_st[k] <= n_st[k];
        end
        r_hue   <= n_hue;
        r_sat   <= n_sat;
        r_light <= n_light;
    end

    assign o_strobe    = r_out_v;
    assign o_hue_deg   = r_hue;
    assign o_sat_pct   = r_sat;
    assign o_light_pct = r_light;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(rth_pkg::LATENCY) o_strobe)
        else $error("word lost in pipeline");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[QW] && !r_st[QW].grey |->
            r_st[QW].hrem < rth_pkg::HNUM_W'(r_st[QW].hden) &&
            r_st[QW].srem < rth_pkg::SNUM_W'(r_st[QW].sden))
        else $error("divider remainder not reduced");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_hue_deg <= rth_pkg::HUE_W'(rth_pkg::HUE_MAX) &&
                     o_sat_pct <= rth_pkg::SAT_W'(rth_pkg::PCT_MAX) &&
                     o_light_pct <= rth_pkg::LIGHT_W'(rth_pkg::PCT_MAX))
        else $error("result out of range");

endmodule

FILE: tb/sv/tb.sv
module tb;

    // run bounds, in clocks
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_LIMIT  = rth_pkg::LATENCY * 8 + 100;
    localparam int RANDOM_WORDS = 1030;

    typedef struct packed {
        logic [rth_pkg::CHAN_W-1:0] red;
        logic [rth_pkg::CHAN_W-1:0] green;
        logic [rth_pkg::CHAN_W-1:0] blue;
    } t_rgb_word;

    typedef struct packed {
        logic [rth_pkg::HUE_W-1:0]   hue;
        logic [rth_pkg::SAT_W-1:0]   sat;
        logic [rth_pkg::LIGHT_W-1:0] light;
    } t_hsl_word;

    // every input is known from time zero
    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       start      = 1'b0;
    logic [rth_pkg::CHAN_W-1:0] i_red_in   = '0;
    logic [rth_pkg::CHAN_W-1:0] i_green_in = '0;
    logic [rth_pkg::CHAN_W-1:0] i_blue_in  = '0;

    logic                        busy;
    logic                        o_strobe;
    logic [rth_pkg::HUE_W-1:0]   o_hue_deg;
    logic [rth_pkg::SAT_W-1:0]   o_sat_pct;
    logic [rth_pkg::LIGHT_W-1:0] o_light_pct;

    // hsl words still owed by the block, oldest first
    t_hsl_word pending_hsl[$];
    int        error_count = 0;

    rgb_to_hsl_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_strobe    (o_strobe),
        .o_hue_deg   (o_hue_deg),
        .o_sat_pct   (o_sat_pct),
        .o_light_pct (o_light_pct)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // exact integer hsl conversion, every value rounded half up
    function automatic t_hsl_word convert_rgb(input logic [rth_pkg::CHAN_W-1:0] r8,
                                              input logic [rth_pkg::CHAN_W-1:0] g8,
                                              input logic [rth_pkg::CHAN_W-1:0] b8);
        int r, g, b, mx, mn, d, sum, den, n;
        int hue, sat, light;
        t_hsl_word w;
        r = int'(r8);
        g = int'(g8);
        b = int'(b8);
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d   = mx - mn;
        sum = mx + mn;
        // lightness is sum over 510, in percent
        light = (200 * sum + 510) / 1020;
        hue = 0;
        sat = 0;
        if (d != 0) begin
            // saturation divides by the distance to the nearer end
            den = (sum <= 255) ? sum : 510 - sum;
            if (den > 0) sat = (200 * d + den) / (2 * den);
            // hue numerator is hue times d; red wins ties, then green
            if (mx == r) begin
                n = 60 * (g - b);
                if (g < b) n += 360 * d;
            end else if (mx == g) begin
                n = 60 * (b - r) + 120 * d;
            end else begin
                n = 60 * (r - g) + 240 * d;
            end
            if (n < 0) n = 0;
            hue = (2 * n + d) / (2 * d);
        end
        if (hue > rth_pkg::HUE_MAX) hue = rth_pkg::HUE_MAX;
        if (sat > rth_pkg::PCT_MAX) sat = rth_pkg::PCT_MAX;
        if (light > rth_pkg::PCT_MAX) light = rth_pkg::PCT_MAX;
        w.hue   = hue[rth_pkg::HUE_W-1:0];
        w.sat   = sat[rth_pkg::SAT_W-1:0];
        w.light = light[rth_pkg::LIGHT_W-1:0];
        return w;
    endfunction

    // drive one pixel and hold it until the block takes it; start stays high
    // afterward so that a following word can go out in the very next cycle
    task automatic send_pixel(input logic [rth_pkg::CHAN_W-1:0] r,
                              input logic [rth_pkg::CHAN_W-1:0] g,
                              input logic [rth_pkg::CHAN_W-1:0] b);
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_hsl.push_back(convert_rgb(r, g, b));
    endtask

    // drop start and wait for every owed hsl word, within a bound
    task automatic wait_all_results();
        int waited;
        start  <= 1'b0;
        waited = 0;
        while (pending_hsl.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_hsl.size() != 0) begin
            $error("hsl words never delivered: %0d", pending_hsl.size());
            error_count++;
            pending_hsl.delete();
        end
    endtask

    // random pixel, weighted toward ties, greys, rails and near-greys
    function automatic t_rgb_word random_pixel();
        t_rgb_word px;
        int        mode, v, dr, dg;
        mode = $urandom_range(0, 9);
        px.red   = rth_pkg::CHAN_W'($urandom_range(0, 255));
        px.green = rth_pkg::CHAN_W'($urandom_range(0, 255));
        px.blue  = rth_pkg::CHAN_W'($urandom_range(0, 255));
        v = $urandom_range(0, 255);
        case (mode)
            6: begin
                // grey
                px = {3{v[rth_pkg::CHAN_W-1:0]}};
            end
            7: begin
                // two channels share the maximum
                case ($urandom_range(0, 2))
                    0: begin
                        px.green = px.red;
                        if (px.blue > px.red) px.blue = px.red;
                    end
                    1: begin
                        px.blue = px.green;
                        if (px.red > px.green) px.red = px.green;
                    end
                    default: begin
                        px.blue = px.red;
                        if (px.green > px.red) px.green = px.red;
                    end
                endcase
            end
            8: begin
                // channels pinned to the rails
                if ($urandom_range(0, 2) == 0) px.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
                if ($urandom_range(0, 2) == 0) px.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
                if ($urandom_range(0, 2) == 0) px.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            9: begin
                // near grey, small d stresses the hue rounding
                dr = v + int'($urandom_range(0, 3));
                dg = v + int'($urandom_range(0, 3));
                px.red   = (dr > 255) ? 8'hff : dr[rth_pkg::CHAN_W-1:0];
                px.green = (dg > 255) ? 8'hff : dg[rth_pkg::CHAN_W-1:0];
                px.blue  = v[rth_pkg::CHAN_W-1:0];
            end
            default: begin
            end
        endcase
        return px;
    endfunction

    // rails, primaries, greys, lightness and saturation boundaries, and a
    // hue just below 360 that must round up to 360
    task automatic test_corner_pixels();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd1,   8'd1);
        send_pixel(8'd128, 8'd127, 8'd127);
        send_pixel(8'd128, 8'd128, 8'd127);
        send_pixel(8'd255, 8'd200, 8'd100);
        send_pixel(8'd10,  8'd200, 8'd50);
        send_pixel(8'd30,  8'd60,  8'd220);
        send_pixel(8'd1,   8'd2,   8'd3);
        send_pixel(8'd254, 8'd255, 8'd253);
    endtask

    // ties for the largest channel: red beats green, green beats blue
    task automatic test_tie_breaks();
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd200, 8'd200, 8'd100);
        send_pixel(8'd100, 8'd200, 8'd200);
        send_pixel(8'd200, 8'd100, 8'd200);
    endtask

    // random pixels in bursts with random gaps, some bursts back to back;
    // start is left to the caller to drop at the end
    task automatic test_random_stream(input int count);
        int        sent, burst, gap;
        t_rgb_word px;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 48);
            for (int k = 0; k < burst && sent < count; k++) begin
                px = random_pixel();
                send_pixel(px.red, px.green, px.blue);
                sent++;
            end
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = 1;
                2:       gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 20);
            endcase
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // compare each strobed hsl word with the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($isunknown(o_strobe)) begin
                $error("o_strobe unknown");
                error_count++;
            end else if (o_strobe) begin
                if (pending_hsl.size() == 0) begin
                    $error("unexpected hsl word: hue %0d sat %0d light %0d",
                           o_hue_deg, o_sat_pct, o_light_pct);
                    error_count++;
                end else begin
                    if (o_hue_deg !== pending_hsl[0].hue) begin
                        $error("hue_deg: expected %0d, got %0d",
                               pending_hsl[0].hue, o_hue_deg);
                        error_count++;
                    end
                    if (o_sat_pct !== pending_hsl[0].sat) begin
                        $error("sat_pct: expected %0d, got %0d",
                               pending_hsl[0].sat, o_sat_pct);
                        error_count++;
                    end
                    if (o_light_pct !== pending_hsl[0].light) begin
                        $error("light_pct: expected %0d, got %0d",
                               pending_hsl[0].light, o_light_pct);
                        error_count++;
                    end
                    void'(pending_hsl.pop_front());
                end
            end
        end
    end

    // hard stop for a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: errors");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_pixels();
        test_tie_breaks();
        // hold off until the pipeline is empty before the random stream starts
        wait_all_results();
        test_random_stream(RANDOM_WORDS);
        wait_all_results();
        // watch for stray strobes after the last word
        repeat (rth_pkg::LATENCY + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
